// ----- src/assert_macros.svh -----
// assertion macros used by the rtl top level
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PAEB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define PAEB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PAEB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PAEB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/paeb_pkg.sv -----
// types, constants and helpers of the envelope bank
// no dependencies
package paeb_pkg;

  localparam int VOICE_COUNT = 8;
  localparam int LEN_W       = 20;
  localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int LVL_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 20;
  localparam int MAX_OUT     = 8;
  localparam int OUT_CNT_W   = 4;
  localparam int QUO_W       = 17;
  localparam int DCNT_W      = 5;

  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(65536);
  localparam logic [LEN_W-1:0] LEN_MAX    = '1;

  localparam logic [2:0] ST_ATTACK  = 3'd0;
  localparam logic [2:0] ST_DECAY   = 3'd1;
  localparam logic [2:0] ST_SUSTAIN = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_OFF     = 3'd4;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] note;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic             report_kind;
    logic [2:0]       voice_index;
    logic             voice_active;
    logic [6:0]       voice_note;
    logic [6:0]       voice_velocity;
    logic [LVL_W-1:0] amp_out;
    logic [LVL_W-1:0] filter_out;
    logic             last;
  } out_item_t;

  function automatic logic [LEN_W-1:0] clip_len(input logic [CFG_DATA_W-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return (wide > 64'(LEN_MAX)) ? LEN_MAX : LEN_W'(wide);
  endfunction

endpackage

// ----- src/polyphonic_adsr_envelope_bank_unit.sv -----
// envelope bank top level: voice state, sequencer, shared multiply and divide unit
// depends on paeb_pkg and assert_macros.svh
//
//  channel  dir  handshake                  payload
//  in       in   in_valid_i / in_ready_o    in_data_i (in_item_t)
//  out      out  out_valid_o / out_ready_i  out_data_o (out_item_t)
//  cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// tick: scans every voice, updates and reports each active one; each of its two
// envelopes may take a multiply and 17 restoring divide steps
// note on emits a report of its voice; reset clears all voice state at once
// a waiting output result stalls the sequencer; input is taken only while idle
`include "assert_macros.svh"
module polyphonic_adsr_envelope_bank_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  paeb_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output paeb_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [paeb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [paeb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import paeb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ENV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [VOICE_W-1:0] vidx_q, vidx_d;
  logic env_q, env_d;
  logic kind_q, kind_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;

  logic [LEN_W-1:0] attack_q, decay_q, release_q;
  logic [LVL_W-1:0] sustain_q;

  logic [VOICE_COUNT-1:0] active_q;
  logic [6:0] note_q [VOICE_COUNT];
  logic [6:0] vel_q  [VOICE_COUNT];
  logic [2:0]       stage_q  [2][VOICE_COUNT];
  logic [LVL_W-1:0] level_q  [2][VOICE_COUNT];
  logic [LEN_W-1:0] count_q  [2][VOICE_COUNT];
  logic [LEN_W-1:0] len_q    [2][VOICE_COUNT];
  logic [LVL_W-1:0] rstart_q [2][VOICE_COUNT];

  logic [2:0]       pst_q, pst_d;
  logic [LEN_W-1:0] pcount_q, pcount_d, plen_q, plen_d, den_q, den_d;
  logic [LEN_W-1:0] mula_q, mula_d, rem_q, rem_d;
  logic [LVL_W-1:0] plevel_q, plevel_d, mulb_q, mulb_d;
  logic             psub_q, psub_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic in_acc, out_free;
  logic [VOICE_W-1:0] pick;
  logic [LVL_W-1:0] sus;

  // current envelope
  logic [2:0]       cur_stage;
  logic [LVL_W-1:0] cur_level, cur_rstart;
  logic [LEN_W-1:0] cur_count, cur_len, c_inc;
  logic [2:0]       e_stage;
  logic [LEN_W-1:0] e_count, e_len, e_mula;
  logic [LVL_W-1:0] e_level, e_mulb;
  logic             e_div, e_sub;

  logic [LEN_W+LVL_W-1:0] prod;
  logic [LEN_W:0]         trial;
  logic                   ge;
  logic [QUO_W-1:0]       quo_fin;

  logic [VOICE_COUNT-1:0] above;
  logic later_active, amp_sounding, advance_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign sus         = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;

  always_comb begin
    pick = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!active_q[v]) pick = VOICE_W'(v);
    end
  end

  assign cur_stage  = stage_q[env_q][vidx_q];
  assign cur_level  = level_q[env_q][vidx_q];
  assign cur_count  = count_q[env_q][vidx_q];
  assign cur_len    = len_q[env_q][vidx_q];
  assign cur_rstart = rstart_q[env_q][vidx_q];
  assign c_inc      = (cur_count == LEN_MAX) ? cur_count : cur_count + LEN_W'(1);

  always_comb begin
    e_stage = cur_stage;
    e_count = c_inc;
    e_len   = cur_len;
    e_level = cur_level;
    e_div   = 1'b0;
    e_sub   = 1'b0;
    e_mula  = '0;
    e_mulb  = '0;
    unique case (cur_stage)
      ST_ATTACK: begin
        if (cur_len == '0) begin
          e_level = FULL_SCALE;
        end else begin
          e_div  = 1'b1;
          e_mula = c_inc;
          e_mulb = FULL_SCALE;
        end
        if (c_inc >= cur_len) begin
          e_stage = ST_DECAY;
          e_count = '0;
          e_len   = clip_len(CFG_DATA_W'(decay_q));
        end
      end
      ST_DECAY: begin
        if (cur_len == '0 || c_inc >= cur_len) begin
          e_stage = ST_SUSTAIN;
          e_level = sus;
        end else begin
          e_div  = 1'b1;
          e_sub  = 1'b1;
          e_mula = c_inc;
          e_mulb = FULL_SCALE - sus;
        end
      end
      ST_SUSTAIN: e_level = sus;
      ST_RELEASE: begin
        if (cur_len != '0 && c_inc < cur_len) begin
          e_div  = 1'b1;
          e_mula = cur_len - c_inc;
          e_mulb = cur_rstart;
        end else begin
          e_level = '0;
        end
        if (c_inc >= cur_len) e_stage = ST_OFF;
      end
      default: ;
    endcase
  end

  // shared multiplier and restoring divide step
  assign prod    = mula_q * mulb_q;
  assign trial   = {rem_q, quo_q[QUO_W-1]};
  assign ge      = (trial >= {1'b0, den_q});
  assign quo_fin = {quo_q[QUO_W-2:0], ge};

  always_comb begin
    for (int v = 0; v < VOICE_COUNT; v++) above[v] = (v > int'(vidx_q));
  end
  assign later_active = |(active_q & above);
  assign amp_sounding = (stage_q[0][vidx_q] == ST_RELEASE) ||
                        (stage_q[0][vidx_q] <= ST_SUSTAIN);
  assign advance_last = (int'(vidx_q) == VOICE_COUNT - 1);

  always_comb begin
    state_d     = state_q;
    vidx_d      = vidx_q;
    env_d       = env_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    pst_d       = pst_q;
    pcount_d    = pcount_q;
    plen_d      = plen_q;
    plevel_d    = plevel_q;
    psub_d      = psub_q;
    mula_d      = mula_q;
    mulb_d      = mulb_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.operation == OP_TICK) begin
            vidx_d  = '0;
            cnt_d   = '0;
            kind_d  = 1'b0;
            state_d = S_SCAN;
          end else if (in_data_i.operation == OP_NOTE_ON) begin
            vidx_d  = pick;
            kind_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (active_q[vidx_q]) begin
          env_d   = 1'b0;
          state_d = S_ENV;
        end else if (advance_last) begin
          state_d = S_IDLE;
        end else begin
          vidx_d = vidx_q + VOICE_W'(1);
        end
      end
      S_ENV: begin
        pst_d    = e_stage;
        pcount_d = e_count;
        plen_d   = e_len;
        plevel_d = e_level;
        psub_d   = e_sub;
        mula_d   = e_mula;
        mulb_d   = e_mulb;
        den_d    = cur_len;
        state_d  = e_div ? S_MUL : S_WB;
      end
      S_MUL: begin
        rem_d   = prod[LEN_W+LVL_W-1:QUO_W];
        quo_d   = prod[QUO_W-1:0];
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = ge ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
        quo_d  = quo_fin;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(QUO_W - 1)) begin
          plevel_d = psub_q ? FULL_SCALE - LVL_W'(quo_fin) : LVL_W'(quo_fin);
          state_d  = S_WB;
        end
      end
      S_WB: begin
        if (!env_q) begin
          env_d   = 1'b1;
          state_d = S_ENV;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (kind_q) begin
          if (out_free) begin
            out_valid_d          = 1'b1;
            out_d.report_kind    = 1'b1;
            out_d.voice_index    = 3'(vidx_q);
            out_d.voice_active   = active_q[vidx_q];
            out_d.voice_note     = note_q[vidx_q];
            out_d.voice_velocity = vel_q[vidx_q];
            out_d.amp_out        = level_q[0][vidx_q];
            out_d.filter_out     = level_q[1][vidx_q];
            out_d.last           = 1'b1;
            state_d              = S_IDLE;
          end
        end else if (cnt_q >= OUT_CNT_W'(MAX_OUT) || out_free) begin
          if (cnt_q < OUT_CNT_W'(MAX_OUT)) begin
            out_valid_d          = 1'b1;
            out_d.report_kind    = 1'b0;
            out_d.voice_index    = 3'(vidx_q);
            out_d.voice_active   = active_q[vidx_q];
            out_d.voice_note     = note_q[vidx_q];
            out_d.voice_velocity = vel_q[vidx_q];
            out_d.amp_out        = level_q[0][vidx_q];
            out_d.filter_out     = level_q[1][vidx_q];
            out_d.last           = (cnt_q == OUT_CNT_W'(MAX_OUT - 1)) || !later_active;
            cnt_d                = cnt_q + OUT_CNT_W'(1);
          end
          if (advance_last) begin
            state_d = S_IDLE;
          end else begin
            vidx_d  = vidx_q + VOICE_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= '0;
      env_q       <= 1'b0;
      kind_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      vidx_q      <= vidx_d;
      env_q       <= env_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pst_q    <= pst_d;
    pcount_q <= pcount_d;
    plen_q   <= plen_d;
    plevel_q <= plevel_d;
    psub_q   <= psub_d;
    mula_q   <= mula_d;
    mulb_q   <= mulb_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= clip_len(CFG_DATA_W'(480));
      decay_q   <= clip_len(CFG_DATA_W'(4800));
      sustain_q <= LVL_W'(45875);
      release_q <= clip_len(CFG_DATA_W'(9600));
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ATTACK:  attack_q  <= LEN_W'(cfg_data_i);
        REG_DECAY:   decay_q   <= LEN_W'(cfg_data_i);
        REG_SUSTAIN: sustain_q <= cfg_data_i[LVL_W-1:0];
        REG_RELEASE: release_q <= LEN_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // voice state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        note_q[v] <= '0;
        vel_q[v]  <= '0;
        for (int e = 0; e < 2; e++) begin
          stage_q[e][v]  <= ST_ATTACK;
          level_q[e][v]  <= '0;
          count_q[e][v]  <= '0;
          len_q[e][v]    <= '0;
          rstart_q[e][v] <= '0;
        end
      end
    end else begin
      if (in_acc && in_data_i.operation == OP_NOTE_ON) begin
        active_q[pick] <= 1'b1;
        note_q[pick]   <= in_data_i.note;
        vel_q[pick]    <= in_data_i.velocity;
        for (int e = 0; e < 2; e++) begin
          stage_q[e][pick]  <= ST_ATTACK;
          level_q[e][pick]  <= '0;
          count_q[e][pick]  <= '0;
          rstart_q[e][pick] <= '0;
        end
        len_q[0][pick] <= clip_len(CFG_DATA_W'(attack_q));
        len_q[1][pick] <= clip_len(CFG_DATA_W'(attack_q >> 1));
      end
      if (in_acc && in_data_i.operation == OP_NOTE_OFF) begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (active_q[v] && note_q[v] == in_data_i.note) begin
            for (int e = 0; e < 2; e++) begin
              if (stage_q[e][v] != ST_RELEASE) begin
                stage_q[e][v]  <= ST_RELEASE;
                count_q[e][v]  <= '0;
                len_q[e][v]    <= clip_len(CFG_DATA_W'(release_q));
                rstart_q[e][v] <= level_q[e][v];
              end
            end
          end
        end
      end
      if (state_q == S_WB) begin
        stage_q[env_q][vidx_q] <= pst_q;
        count_q[env_q][vidx_q] <= pcount_q;
        len_q[env_q][vidx_q]   <= plen_q;
        level_q[env_q][vidx_q] <= plevel_q;
        if (env_q && !amp_sounding) active_q[vidx_q] <= 1'b0;
      end
    end
  end

  `PAEB_ASSERT_IMP(a_div_nonzero, clk_i, rst_ni, state_q == S_DIV, den_q != '0)
  `PAEB_ASSERT_IMP(a_level_range, clk_i, rst_ni, state_q == S_WB, plevel_q <= FULL_SCALE)
  `PAEB_ASSERT_NXT(a_note_on_emit, clk_i, rst_ni,
                   in_acc && in_data_i.operation == OP_NOTE_ON,
                   state_q == S_EMIT && kind_q && active_q[vidx_q])

endmodule
